// ----- rtl/vgm_pkg.sv -----
// Shared types and codes of the volume gradient magnitude core.
`default_nettype none
package vgm_pkg;

    typedef logic [11:0] xy_t;
    typedef logic [11:0] z_t;
    typedef logic [15:0] sample_t;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_DEPTH  = 2'd2;

    localparam logic KIND_VOXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // One unit of work for the back end.
    typedef struct packed {
        logic    wr_en;
        logic    has_res;
        logic    from_store;
        logic    last;
        logic    slot;
        logic    zl_slot;
        logic    wr_slot;
        xy_t     x;
        xy_t     y;
        xy_t     px;
        xy_t     nx;
        xy_t     py;
        xy_t     ny;
        z_t      pos_z;
        sample_t sample;
    } job_t;

    typedef struct packed {
        logic [15:0] magnitude;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [11:0] pos_z;
        logic        last;
    } res_t;

endpackage
`default_nettype wire

// ----- rtl/vgm_front.sv -----
// Front end: configuration registers, voxel and drain counters, job building.
`default_nettype none
module vgm_front #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int MAX_DEPTH   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire logic                           kind,
    input  wire logic [15:0]                    sample,
    input  wire logic                           cfg_valid,
    input  wire logic [vgm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [12:0]                    cfg_data,
    input  wire logic                           job_full,
    output logic                                job_push,
    output vgm_pkg::job_t                       job
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int ZW = $clog2(MAX_DEPTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam logic [15:0] SMASK =
        (SAMPLE_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << SAMPLE_BITS) - 64'd1);

    logic [8:0]    width_reg;
    logic [8:0]    height_reg;
    logic [12:0]   depth_reg;
    logic [XW-1:0] in_x_reg, out_x_reg, cur_x, px, nx;
    logic [YW-1:0] in_y_reg, out_y_reg, cur_y, py, ny;
    logic [ZW-1:0] in_z_reg, out_z_reg;
    logic          complete_reg;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [DW-1:0] d_eff;
    logic          accept;
    logic          x_end, y_end, z_end;

    always_comb
    begin
        w_eff = (width_reg == 9'd0) ? WW'(1) :
                ((32'(width_reg) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_reg));
        h_eff = (height_reg == 9'd0) ? HW'(1) :
                ((32'(height_reg) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_reg));
        d_eff = (depth_reg == 13'd0) ? DW'(1) :
                ((32'(depth_reg) > MAX_DEPTH) ? DW'(MAX_DEPTH) : DW'(depth_reg));
    end

    assign accept   = push && !job_full;
    assign job_push = accept && ((kind == vgm_pkg::KIND_VOXEL) ? !complete_reg : complete_reg);
    assign cur_x    = complete_reg ? out_x_reg : in_x_reg;
    assign cur_y    = complete_reg ? out_y_reg : in_y_reg;
    assign x_end    = !(32'(cur_x) + 32'd1 < 32'(w_eff));
    assign y_end    = !(32'(cur_y) + 32'd1 < 32'(h_eff));
    assign z_end    = !(32'(in_z_reg) + 32'd1 < 32'(d_eff));

    // Neighbor coordinates clamped to the volume.
    always_comb
    begin
        px = (cur_x == '0) ? '0 : XW'(32'(cur_x) - 32'd1);
        nx = x_end ? XW'(32'(w_eff) - 32'd1) : XW'(32'(cur_x) + 32'd1);
        py = (cur_y == '0) ? '0 : YW'(32'(cur_y) - 32'd1);
        ny = y_end ? YW'(32'(h_eff) - 32'd1) : YW'(32'(cur_y) + 32'd1);
    end

    always_comb
    begin
        job.x      = vgm_pkg::xy_t'(cur_x);
        job.y      = vgm_pkg::xy_t'(cur_y);
        job.px     = vgm_pkg::xy_t'(px);
        job.nx     = vgm_pkg::xy_t'(nx);
        job.py     = vgm_pkg::xy_t'(py);
        job.ny     = vgm_pkg::xy_t'(ny);
        job.sample = sample & SMASK;
        if (complete_reg)
        begin
            job.wr_en      = 1'b0;
            job.has_res    = 1'b1;
            job.from_store = 1'b1;
            job.last       = x_end && y_end;
            job.slot       = out_z_reg[0];
            job.zl_slot    = (out_z_reg == '0) ? out_z_reg[0] : ~out_z_reg[0];
            job.wr_slot    = out_z_reg[0];
            job.pos_z      = vgm_pkg::z_t'(out_z_reg);
        end
        else
        begin
            job.wr_en      = 1'b1;
            job.has_res    = (in_z_reg != '0);
            job.from_store = 1'b0;
            job.last       = 1'b0;
            job.slot       = ~in_z_reg[0];
            job.zl_slot    = (32'(in_z_reg) == 32'd1) ? 1'b0 : in_z_reg[0];
            job.wr_slot    = in_z_reg[0];
            job.pos_z      = vgm_pkg::z_t'(32'(in_z_reg) - 32'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            depth_reg  <= 13'd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                vgm_pkg::REG_VOLUME_WIDTH:  width_reg  <= cfg_data[8:0];
                vgm_pkg::REG_VOLUME_HEIGHT: height_reg <= cfg_data[8:0];
                vgm_pkg::REG_VOLUME_DEPTH:  depth_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_x_reg     <= '0;
            in_y_reg     <= '0;
            in_z_reg     <= '0;
            out_x_reg    <= '0;
            out_y_reg    <= '0;
            out_z_reg    <= '0;
            complete_reg <= 1'b0;
        end
        else if (job_push)
        begin
            if (!complete_reg)
            begin
                if (!x_end)
                    in_x_reg <= XW'(32'(in_x_reg) + 32'd1);
                else
                begin
                    in_x_reg <= '0;
                    if (!y_end)
                        in_y_reg <= YW'(32'(in_y_reg) + 32'd1);
                    else
                    begin
                        in_y_reg <= '0;
                        if (!z_end)
                            in_z_reg <= ZW'(32'(in_z_reg) + 32'd1);
                        else
                        begin
                            in_z_reg     <= '0;
                            complete_reg <= 1'b1;
                            out_x_reg    <= '0;
                            out_y_reg    <= '0;
                            out_z_reg    <= in_z_reg;
                        end
                    end
                end
            end
            else if (x_end && y_end)
            begin
                complete_reg <= 1'b0;
                out_x_reg    <= '0;
                out_y_reg    <= '0;
                out_z_reg    <= '0;
                in_x_reg     <= '0;
                in_y_reg     <= '0;
                in_z_reg     <= '0;
            end
            else if (!x_end)
                out_x_reg <= XW'(32'(out_x_reg) + 32'd1);
            else
            begin
                out_x_reg <= '0;
                out_y_reg <= YW'(32'(out_y_reg) + 32'd1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/vgm_queue.sv -----
// Two-entry job queue between the front end and the back end.
`default_nettype none
module vgm_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr,
    input  wire vgm_pkg::job_t wr_job,
    input  wire logic          rd,
    output vgm_pkg::job_t      rd_job,
    output logic               full,
    output logic               empty
);

    vgm_pkg::job_t entry_reg [0:1];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full   = (count_reg == 2'd2);
    assign empty  = (count_reg == 2'd0);
    assign rd_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            entry_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (wr && !rd)
                count_reg <= count_reg + 2'd1;
            else if (rd && !wr)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/vgm_back.sv -----
// Back end: two-plane store, neighbor reads, sum of squares, serial square root.
`default_nettype none
module vgm_back #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_empty,
    input  wire vgm_pkg::job_t job_head,
    output logic               job_pop,
    input  wire logic          res_pop,
    output logic               res_valid,
    output vgm_pkg::res_t      res
);

    localparam int PLANE = MAX_WIDTH * MAX_HEIGHT;
    localparam int DEPTH = 2 * PLANE;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [32:0] SAT = 33'((64'd1 << SAMPLE_BITS) - 64'd1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [15:0]   store_mem [DEPTH];
    logic [15:0]   rd_data_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    vgm_pkg::job_t wr_src;

    logic [2:0]    state_reg;
    logic [4:0]    step_reg;
    vgm_pkg::job_t job_reg;
    logic [15:0]   vals_reg [0:5];
    logic [33:0]   acc_reg, acc_next;
    logic [33:0]   rad_reg;
    logic [19:0]   rem_reg, rem_sh, trial;
    logic [16:0]   root_reg;
    logic          res_valid_reg;
    vgm_pkg::res_t res_reg;
    logic          load;

    vgm_pkg::xy_t  rx, ry;
    logic          rsl;
    logic [15:0]   op_a, op_b, diff;
    logic [31:0]   sq;
    logic [15:0]   mag;

    // Read address for the current read step.
    always_comb
    begin
        rx  = job_reg.x;
        ry  = job_reg.y;
        rsl = job_reg.slot;
        unique case (step_reg[2:0])
            3'd0:    rx = job_reg.px;
            3'd1:    rx = job_reg.nx;
            3'd2:    ry = job_reg.py;
            3'd3:    ry = job_reg.ny;
            3'd4:    rsl = job_reg.zl_slot;
            default: ;
        endcase
        rd_addr = AW'(32'(rsl) * PLANE + 32'(ry) * MAX_WIDTH + 32'(rx));
    end

    assign wr_src  = (state_reg == ST_IDLE) ? job_head : job_reg;
    assign wr_en   = ((state_reg == ST_IDLE) && !job_empty && job_head.wr_en
                      && !job_head.has_res)
                  || ((state_reg == ST_READ) && (step_reg == 5'd6) && job_reg.wr_en);
    assign wr_addr = AW'(32'(wr_src.wr_slot) * PLANE + 32'(wr_src.y) * MAX_WIDTH
                         + 32'(wr_src.x));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_src.sample;
        rd_data_reg <= store_mem[rd_addr];
    end

    // One squared difference per cycle into the accumulator.
    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0:
            begin
                op_a = vals_reg[0];
                op_b = vals_reg[1];
            end
            2'd1:
            begin
                op_a = vals_reg[2];
                op_b = vals_reg[3];
            end
            default:
            begin
                op_a = vals_reg[4];
                op_b = job_reg.from_store ? vals_reg[5] : job_reg.sample;
            end
        endcase
        diff     = (op_a > op_b) ? op_a - op_b : op_b - op_a;
        sq       = diff * diff;
        acc_next = acc_reg + 34'(sq);
    end

    assign rem_sh = {rem_reg[17:0], rad_reg[33:32]};
    assign trial  = 20'({root_reg, 2'b01});
    assign mag    = (33'(root_reg) > SAT) ? SAT[15:0] : root_reg[15:0];

    assign job_pop   = (state_reg == ST_IDLE) && !job_empty;
    assign load      = (state_reg == ST_OUT) && (!res_valid_reg || res_pop);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 5'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                res_valid_reg <= 1'b1;
            else if (res_pop)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= 5'd0;
                    if (job_pop && job_head.has_res)
                        state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    if (step_reg == 5'd6)
                    begin
                        step_reg  <= 5'd0;
                        state_reg <= ST_SUM;
                    end
                    else
                        step_reg <= step_reg + 5'd1;
                end
                ST_SUM:
                begin
                    if (step_reg == 5'd2)
                    begin
                        step_reg  <= 5'd0;
                        state_reg <= ST_ROOT;
                    end
                    else
                        step_reg <= step_reg + 5'd1;
                end
                ST_ROOT:
                begin
                    if (step_reg == 5'd16)
                    begin
                        step_reg  <= 5'd0;
                        state_reg <= ST_OUT;
                    end
                    else
                        step_reg <= step_reg + 5'd1;
                end
                ST_OUT:
                begin
                    if (load)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
            job_reg <= job_head;
        if ((state_reg == ST_READ) && (step_reg != 5'd0))
            vals_reg[3'(step_reg - 5'd1)] <= rd_data_reg;
        if ((state_reg == ST_READ) && (step_reg == 5'd6))
            acc_reg <= '0;
        if (state_reg == ST_SUM)
        begin
            acc_reg <= acc_next;
            if (step_reg == 5'd2)
            begin
                rad_reg  <= acc_next;
                rem_reg  <= '0;
                root_reg <= '0;
            end
        end
        if (state_reg == ST_ROOT)
        begin
            rad_reg <= {rad_reg[31:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[15:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[15:0], 1'b0};
            end
        end
        if (load)
        begin
            res_reg.magnitude <= mag;
            res_reg.pos_x     <= job_reg.x[7:0];
            res_reg.pos_y     <= job_reg.y[7:0];
            res_reg.pos_z     <= job_reg.pos_z;
            res_reg.last      <= job_reg.last;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/volume_gradient_magnitude_core.sv -----
// Top level of the streaming 3-D central-difference gradient magnitude core.
//
//   Channel   Direction  Handshake              Word
//   input     in         push / full            kind, sample
//   result    out        empty / pop            magnitude, pos_x, pos_y, pos_z, last
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Ignored words never reach the back end; a voxel of the first plane is written to the
// plane store in the same cycle in which the back end pops it. A word that produces a
// result holds the back end while it pops the job, makes six reads through the single
// read port of the plane store (the last read step also writes the new sample of a voxel),
// accumulates the squared differences, runs the bit-serial square root and loads the
// output register, and it waits to load while the output register holds an unpopped result.
// Reset clears all counters and sets each size register to 256; the plane store is
// not cleared. A two-entry job queue lets the front keep accepting words while the
// back end computes or while a finished result waits to be popped.
`default_nettype none
module volume_gradient_magnitude_core #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int MAX_DEPTH   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic                           kind,
    input  wire logic [15:0]                    sample,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [15:0]                         magnitude,
    output logic [7:0]                          pos_x,
    output logic [7:0]                          pos_y,
    output logic [11:0]                         pos_z,
    output logic                                last,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [vgm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [12:0]                    cfg_data
);

    logic          job_push;
    logic          job_pop;
    logic          job_full;
    logic          job_empty;
    vgm_pkg::job_t job_in;
    vgm_pkg::job_t job_head;
    logic          res_valid;
    vgm_pkg::res_t res;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    // The front accepts a word whenever the job queue has room.
    assign full = job_full;

    vgm_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_DEPTH   (MAX_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .kind      (kind),
        .sample    (sample),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_full  (job_full),
        .job_push  (job_push),
        .job       (job_in)
    );

    vgm_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (job_push),
        .wr_job (job_in),
        .rd     (job_pop),
        .rd_job (job_head),
        .full   (job_full),
        .empty  (job_empty)
    );

    vgm_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_head  (job_head),
        .job_pop   (job_pop),
        .res_pop   (pop),
        .res_valid (res_valid),
        .res       (res)
    );

    // The output register holds the oldest result until it is popped.
    assign empty     = !res_valid;
    assign magnitude = res.magnitude;
    assign pos_x     = res.pos_x;
    assign pos_y     = res.pos_y;
    assign pos_z     = res.pos_z;
    assign last      = res.last;

    // The back end never takes a job from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) job_pop |-> !job_empty)
        else $error("job popped from empty queue");

    // The front never pushes a job into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) job_push |-> !job_full)
        else $error("job pushed into full queue");

    // A shown magnitude never exceeds the largest sample value.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (33'(magnitude) <= 33'((64'd1 << SAMPLE_BITS) - 64'd1)))
        else $error("magnitude above saturation limit");

endmodule
`default_nettype wire

// ----- verif/vgm_checker.sv -----
// Scoreboard for the volume gradient magnitude core: predicts and compares result words.
`timescale 1ns / 100ps
module vgm_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic                          kind,
    input  logic [15:0]                   sample,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [15:0]                   magnitude,
    input  logic [7:0]                    pos_x,
    input  logic [7:0]                    pos_y,
    input  logic [11:0]                   pos_z,
    input  logic                          last,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [vgm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [12:0]                   cfg_data,
    output int                            errors,
    output int                            pending
);

    localparam int MAXW = 256;
    localparam int MAXH = 256;
    localparam int MAXD = 4096;

    logic [15:0]   plane_mem [0:2*MAXW*MAXH-1];
    int            vox_x, vox_y, vox_z;
    int            drn_x, drn_y, drn_z;
    bit            draining;
    logic [8:0]    width_reg, height_reg;
    logic [12:0]   depth_reg;
    vgm_pkg::res_t result_fifo [$];

    assign pending = result_fifo.size();

    function automatic int clamp_size(int v, int maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic logic [15:0] plane_rd(int slot, int x, int y);
        return plane_mem[(slot & 1) * MAXW * MAXH + (y % MAXH) * MAXW + (x % MAXW)];
    endfunction

    function automatic longint sqdiff(logic [15:0] a, logic [15:0] b);
        longint d;
        d = (a > b) ? longint'(a - b) : longint'(b - a);
        return d * d;
    endfunction

    // Floor of the square root, built one bit at a time, then saturated.
    function automatic logic [15:0] grad_len(int slot, int x, int y,
                                             logic [15:0] zl, logic [15:0] zr);
        int     w, h, px, nx, py, ny;
        longint acc, root;
        w  = clamp_size(width_reg, MAXW);
        h  = clamp_size(height_reg, MAXH);
        px = (x > 0) ? x - 1 : 0;
        nx = (x + 1 < w) ? x + 1 : w - 1;
        py = (y > 0) ? y - 1 : 0;
        ny = (y + 1 < h) ? y + 1 : h - 1;
        acc = sqdiff(plane_rd(slot, px, y), plane_rd(slot, nx, y))
            + sqdiff(plane_rd(slot, x, py), plane_rd(slot, x, ny))
            + sqdiff(zl, zr);
        root = 0;
        for (int b = 20; b >= 0; b--)
        begin
            if ((root | (longint'(1) << b)) * (root | (longint'(1) << b)) <= acc)
                root = root | (longint'(1) << b);
        end
        return (root > 65535) ? 16'hFFFF : root[15:0];
    endfunction

    task automatic predict_word(logic k, logic [15:0] s);
        int   w, h, d, p;
        logic [15:0] zl;
        vgm_pkg::res_t r;
        w = clamp_size(width_reg, MAXW);
        h = clamp_size(height_reg, MAXH);
        d = clamp_size(depth_reg, MAXD);
        if (k == vgm_pkg::KIND_VOXEL)
        begin
            if (draining)
                return;
            if (vox_z >= 1)
            begin
                p  = vox_z - 1;
                zl = (p == 0) ? plane_rd(p, vox_x, vox_y) : plane_rd(p - 1, vox_x, vox_y);
                r.magnitude = grad_len(p, vox_x, vox_y, zl, s);
                r.pos_x = vox_x[7:0];
                r.pos_y = vox_y[7:0];
                r.pos_z = p[11:0];
                r.last  = 1'b0;
                result_fifo.push_back(r);
            end
            plane_mem[(vox_z & 1) * MAXW * MAXH + (vox_y % MAXH) * MAXW + (vox_x % MAXW)] = s;
            if (vox_x + 1 < w)
                vox_x++;
            else
            begin
                vox_x = 0;
                if (vox_y + 1 < h)
                    vox_y++;
                else
                begin
                    vox_y = 0;
                    if (vox_z + 1 < d)
                        vox_z++;
                    else
                    begin
                        drn_x = 0;
                        drn_y = 0;
                        drn_z = vox_z;
                        vox_z = 0;
                        draining = 1'b1;
                    end
                end
            end
        end
        else if (draining)
        begin
            zl = (drn_z == 0) ? plane_rd(drn_z, drn_x, drn_y)
                              : plane_rd(drn_z - 1, drn_x, drn_y);
            r.magnitude = grad_len(drn_z, drn_x, drn_y, zl, plane_rd(drn_z, drn_x, drn_y));
            r.pos_x = drn_x[7:0];
            r.pos_y = drn_y[7:0];
            r.pos_z = drn_z[11:0];
            r.last  = (drn_x + 1 >= w) && (drn_y + 1 >= h);
            result_fifo.push_back(r);
            if (r.last)
            begin
                draining = 1'b0;
                drn_x = 0; drn_y = 0; drn_z = 0;
                vox_x = 0; vox_y = 0; vox_z = 0;
            end
            else if (drn_x + 1 < w)
                drn_x++;
            else
            begin
                drn_x = 0;
                drn_y++;
            end
        end
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vox_x = 0; vox_y = 0; vox_z = 0;
            drn_x = 0; drn_y = 0; drn_z = 0;
            draining   = 1'b0;
            width_reg  = 9'd256;
            height_reg = 9'd256;
            depth_reg  = 13'd256;
            errors     = 0;
            result_fifo.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (result_fifo.size() == 0)
                begin
                    $display("%0t: unexpected result word, magnitude %0d at (%0d,%0d,%0d)",
                             $time, magnitude, pos_x, pos_y, pos_z);
                    errors++;
                end
                else
                begin
                    vgm_pkg::res_t e;
                    e = result_fifo.pop_front();
                    check_field("magnitude", e.magnitude, magnitude);
                    check_field("pos_x", e.pos_x, pos_x);
                    check_field("pos_y", e.pos_y, pos_y);
                    check_field("pos_z", e.pos_z, pos_z);
                    check_field("last", e.last, last);
                end
            end
            if (push && !full)
                predict_word(kind, sample);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    vgm_pkg::REG_VOLUME_WIDTH:  width_reg  = cfg_data[8:0];
                    vgm_pkg::REG_VOLUME_HEIGHT: height_reg = cfg_data[8:0];
                    vgm_pkg::REG_VOLUME_DEPTH:  depth_reg  = cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- verif/testbench.sv -----
// Stimulus, clocking and verdict for the volume gradient magnitude core.
`timescale 1ns / 100ps
module testbench;

    // Longest legal run of cycles with no handshake: the receiver hold-off,
    // a settle pause or a long gap, plus a result's compute time.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 60;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          push = 1'b0;
    logic                          kind = vgm_pkg::KIND_VOXEL;
    logic [15:0]                   sample = '0;
    logic                          pop = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [vgm_pkg::CFG_IDX_W-1:0] cfg_index = vgm_pkg::REG_VOLUME_WIDTH;
    logic [12:0]                   cfg_data = '0;
    logic                          full, empty, cfg_ready, last;
    logic [15:0]                   magnitude;
    logic [7:0]                    pos_x, pos_y;
    logic [11:0]                   pos_z;
    int                            errors, pending;

    // Receiver controls: a one-time long hold-off and a switch for stretches
    // of back-to-back traffic on both sides.
    int hold_off_cycles = 0;
    bit no_gaps = 1'b0;
    int words_sent = 0;
    int quiet_cycles = 0;

    always #6 clk = ~clk;

    volume_gradient_magnitude_core uut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .kind(kind), .sample(sample),
        .empty(empty), .pop(pop),
        .magnitude(magnitude), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    vgm_checker scoreboard (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .kind(kind), .sample(sample),
        .empty(empty), .pop(pop),
        .magnitude(magnitude), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .errors(errors), .pending(pending)
    );

    // Any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones; picked fresh after each idle stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 70)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // The receiver drops pop during gaps and during the one long hold-off.
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                pop <= 1'b0;
                hold_off_cycles--;
            end
            else if (idle > 0)
            begin
                pop <= 1'b0;
                idle--;
            end
            else
            begin
                pop <= 1'b1;
                idle = pick_gap();
            end
        end
    end

    // Offers one word and holds it until the core takes it. Entered and left
    // at a falling edge, so a following word keeps push high without a glitch.
    task automatic send_word(logic k, logic [15:0] s);
        int gap;
        push   <= 1'b1;
        kind   <= k;
        sample <= s;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
        words_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            kind <= $urandom_range(0, 1);
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic write_reg(logic [vgm_pkg::CFG_IDX_W-1:0] idx, logic [12:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Registers are only touched once every expected word is out and the
    // back end has had time to finish any word that makes no result. The
    // sender stops offering first, so the last word is not taken again.
    task automatic settle();
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic int eff_size(int raw, int maxv);
        if (raw == 0)
            return 1;
        return (raw > maxv) ? maxv : raw;
    endfunction

    // Voxel contents: 0 random, 1 checkerboard of the two extremes (forces
    // saturation), 2 a gentle ramp with noise, 3 sparse random bits.
    function automatic logic [15:0] voxel_value(int pattern, int x, int y, int z);
        case (pattern)
            1: return ((x + y + z) & 1) ? 16'hFFFF : 16'h0000;
            2: return 16'((x * 37 + y * 11 + z * 5) + $urandom_range(0, 7));
            3: return 16'($urandom_range(0, 65535) & $urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // One full volume: configure, stream every voxel, then drain the last
    // plane. Stray drain words while streaming and stray voxels while
    // draining are dropped by the core and are mixed in on request.
    task automatic run_volume(int raw_w, int raw_h, int raw_d, int pattern, bit noise);
        int w, h, d;
        w = eff_size(raw_w, 256);
        h = eff_size(raw_h, 256);
        d = eff_size(raw_d, 4096);
        // Upper data bits beyond a register's width are random, so they toggle too.
        write_reg(vgm_pkg::REG_VOLUME_WIDTH,  {4'($urandom_range(0, 15)), 9'(raw_w)});
        write_reg(vgm_pkg::REG_VOLUME_HEIGHT, {4'($urandom_range(0, 15)), 9'(raw_h)});
        write_reg(vgm_pkg::REG_VOLUME_DEPTH,  13'(raw_d));
        for (int z = 0; z < d; z++)
            for (int y = 0; y < h; y++)
                for (int x = 0; x < w; x++)
                begin
                    if (noise && $urandom_range(0, 9) == 0)
                        send_word(vgm_pkg::KIND_DRAIN, 16'($urandom_range(0, 65535)));
                    send_word(vgm_pkg::KIND_VOXEL, voxel_value(pattern, x, y, z));
                end
        for (int i = 0; i < w * h; i++)
        begin
            if (noise && $urandom_range(0, 9) == 0)
                send_word(vgm_pkg::KIND_VOXEL, 16'($urandom_range(0, 65535)));
            send_word(vgm_pkg::KIND_DRAIN, 16'($urandom_range(0, 65535)));
        end
        // A drain word after the volume has ended is ignored as well.
        if (noise)
            send_word(vgm_pkg::KIND_DRAIN, 16'hFFFF);
        settle();
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed: single voxel, saturating checkerboard, zero-sized registers,
        // a single row, and a width register above its largest setting.
        run_volume(1, 1, 1, 0, 1'b1);
        run_volume(3, 3, 3, 1, 1'b0);
        run_volume(0, 0, 0, 0, 1'b1);
        run_volume(2, 1, 3, 2, 1'b0);
        run_volume(511, 1, 1, 3, 1'b0);

        // The receiver stops for a long while as the next volume starts, so
        // the core fills up and has to push back on the sender.
        hold_off_cycles = 400;
        run_volume(4, 4, 3, 0, 1'b0);

        while (words_sent < 800)
        begin
            no_gaps = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 7) == 0)
                run_volume($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 3),
                           $urandom_range(0, 3), $urandom_range(0, 1));
            else
                run_volume($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 5),
                           $urandom_range(0, 3), $urandom_range(0, 1));
        end
        no_gaps = 1'b0;

        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
